// File: src/assert_macros.svh
// assertion macros shared by the rtl files
// needs clk and arst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/ckb_pkg.sv
// shared types and constants of the color key blit block
// no dependencies
`default_nettype none

package ckb_pkg;

	localparam int MAX_COLS_DEF = 128;
	localparam int MAX_ROWS_DEF = 64;

	// width used for all bound compares, holds any column or row limit
	localparam int BOUND_W = 11;

	typedef enum logic [1:0] {
		OP_BLIT  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X      = 3'd0,
		REG_ORIGIN_Y      = 3'd1,
		REG_CANVAS_WIDTH  = 3'd2,
		REG_CANVAS_HEIGHT = 3'd3,
		REG_TRANSP_COLOR  = 3'd4
	} reg_idx_t;

	localparam logic [7:0] ORIGIN_X_RST      = 8'sd0;
	localparam logic [6:0] ORIGIN_Y_RST      = 7'sd0;
	localparam logic [7:0] CANVAS_WIDTH_RST  = 8'd80;
	localparam logic [6:0] CANVAS_HEIGHT_RST = 7'd25;
	localparam logic [7:0] TRANSP_COLOR_RST  = 8'd255;

	typedef struct packed {
		logic [7:0] glyph;
		logic [7:0] fore;
		logic [7:0] back;
	} cell_t;

	localparam cell_t CELL_ZERO = '{glyph: 8'd0, fore: 8'd0, back: 8'd0};

endpackage

`default_nettype wire

// File: src/ckb_canvas.sv
// canvas cell memory: one synchronous read port, one write port
// depends on ckb_pkg; forwards a write that lands on the entry being read
`default_nettype none

module ckb_canvas #(
	parameter int DEPTH = ckb_pkg::MAX_COLS_DEF * ckb_pkg::MAX_ROWS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	input  wire logic                                 wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire ckb_pkg::cell_t                       wr_data,
	output ckb_pkg::cell_t                            rd_data
);

	ckb_pkg::cell_t mem_q [DEPTH];
	ckb_pkg::cell_t rdata_q;
	ckb_pkg::cell_t fwd_data_q;
	logic           fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q    <= mem_q[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// read sees the new data when a write hits the same entry in that cycle: the write data is forwarded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rdata_q;

endmodule

`default_nettype wire

// File: src/color_key_sprite_blit_top.sv
// color key blit block, top level: config registers, clip and address
// stage, merge and write-back stage, output register; uses ckb_pkg, ckb_canvas
// A text-mode canvas of MAX_COLS x MAX_ROWS cells (glyph, foreground,
// background) sits in a synchronous RAM. The canvas read is launched at the
// edge that takes a word; merge and write-back follow from the stage-1
// registers once the output register is free or drained, and the result is
// loaded into the output register at the edge of the write-back. A new word
// is taken every cycle as long as results are drained, so one word per cycle
// sustained. The RAM has a single read port and a registered read; a blit or
// read that hits the cell written by the word just before it gets the written
// value forwarded. The canvas is not cleared at reset: a cell must be written
// before it is read or blitted onto.
// Configuration writes are always taken and are meant only while idle.
`default_nettype none
`include "assert_macros.svh"

module color_key_sprite_blit_top #(
	parameter int MAX_COLS = ckb_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = ckb_pkg::MAX_ROWS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] opcode,
	input  wire logic [6:0] col,
	input  wire logic [5:0] row,
	input  wire logic [7:0] glyph,
	input  wire logic [7:0] fore_color,
	input  wire logic [7:0] back_color,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      cell_glyph,
	output logic [7:0]      cell_fore,
	output logic [7:0]      cell_back,
	output logic            clipped
);

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BW    = ckb_pkg::BOUND_W;

	// configuration registers
	logic [7:0] origin_x_q;
	logic [6:0] origin_y_q;
	logic [7:0] canvas_width_q;
	logic [6:0] canvas_height_q;
	logic [7:0] transp_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q      <= ckb_pkg::ORIGIN_X_RST;
			origin_y_q      <= ckb_pkg::ORIGIN_Y_RST;
			canvas_width_q  <= ckb_pkg::CANVAS_WIDTH_RST;
			canvas_height_q <= ckb_pkg::CANVAS_HEIGHT_RST;
			transp_q        <= ckb_pkg::TRANSP_COLOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ckb_pkg::REG_ORIGIN_X:      origin_x_q      <= cfg_data;
				ckb_pkg::REG_ORIGIN_Y:      origin_y_q      <= cfg_data[6:0];
				ckb_pkg::REG_CANVAS_WIDTH:  canvas_width_q  <= cfg_data;
				ckb_pkg::REG_CANVAS_HEIGHT: canvas_height_q <= cfg_data[6:0];
				ckb_pkg::REG_TRANSP_COLOR:  transp_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: clip and address
	logic           valid_s1;
	logic [1:0]     op_s1;
	logic           clip_s1;
	logic [AW-1:0]  addr_s1;
	ckb_pkg::cell_t pix_s1;

	logic           out_valid_q;
	ckb_pkg::cell_t out_cell_q;
	logic           out_clip_q;

	logic           in_acc;
	logic           s1_adv;

	assign s1_adv   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign in_acc   = in_valid && in_ready;

	logic signed [8:0] dx;
	logic signed [7:0] dy;
	logic [BW-1:0]     w_eff;
	logic [BW-1:0]     h_eff;
	logic              blit_clip;
	logic              cell_clip;
	logic              clip_c;
	logic [8:0]        col_sel;
	logic [7:0]        row_sel;
	logic [AW-1:0]     addr_c;

	always_comb begin
		dx    = $signed({origin_x_q[7], origin_x_q}) + $signed({2'b00, col});
		dy    = $signed({origin_y_q[6], origin_y_q}) + $signed({2'b00, row});
		w_eff = (BW'(canvas_width_q) < BW'(MAX_COLS)) ? BW'(canvas_width_q) : BW'(MAX_COLS);
		h_eff = (BW'(canvas_height_q) < BW'(MAX_ROWS)) ? BW'(canvas_height_q) : BW'(MAX_ROWS);
		blit_clip = dx[8] || dy[7] || (BW'(dx[7:0]) >= w_eff) || (BW'(dy[6:0]) >= h_eff);
		cell_clip = (BW'(col) >= BW'(MAX_COLS)) || (BW'(row) >= BW'(MAX_ROWS));
		if (opcode == ckb_pkg::OP_BLIT) begin
			clip_c  = blit_clip;
			col_sel = {1'b0, dx[7:0]};
			row_sel = {1'b0, dy[6:0]};
		end else begin
			clip_c  = cell_clip;
			col_sel = {2'b00, col};
			row_sel = {2'b00, row};
		end
		addr_c = AW'(int'(row_sel) * MAX_COLS + int'(col_sel));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= opcode;
			clip_s1 <= clip_c;
			addr_s1 <= addr_c;
			pix_s1  <= '{glyph: glyph, fore: fore_color, back: back_color};
		end
	end

	// stage 2: merge with the stored cell and write back
	logic           wr_en;
	ckb_pkg::cell_t base_cell;
	ckb_pkg::cell_t merged;
	ckb_pkg::cell_t wr_data;
	ckb_pkg::cell_t res_cell;
	logic           res_clip;

	ckb_canvas #(
		.DEPTH(DEPTH)
	) u_canvas (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc && !clip_c),
		.rd_addr (addr_c),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (wr_data),
		.rd_data (base_cell)
	);

	always_comb begin
		merged       = base_cell;
		if (pix_s1.glyph != 8'd0) merged.glyph = pix_s1.glyph;
		if (pix_s1.fore != transp_q) merged.fore = pix_s1.fore;
		if (pix_s1.back != transp_q) merged.back = pix_s1.back;

		wr_en    = 1'b0;
		wr_data  = merged;
		res_cell = ckb_pkg::CELL_ZERO;
		res_clip = 1'b0;
		if (clip_s1 && (op_s1 == ckb_pkg::OP_BLIT || op_s1 == ckb_pkg::OP_WRITE
				|| op_s1 == ckb_pkg::OP_READ)) begin
			res_clip = 1'b1;
		end else begin
			case (op_s1)
				ckb_pkg::OP_BLIT: begin
					wr_en    = s1_adv;
					res_cell = merged;
				end
				ckb_pkg::OP_WRITE: begin
					wr_en    = s1_adv;
					wr_data  = pix_s1;
					res_cell = pix_s1;
				end
				ckb_pkg::OP_READ: begin
					res_cell = base_cell;
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_cell_q <= res_cell;
			out_clip_q <= res_clip;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_glyph = out_cell_q.glyph;
	assign cell_fore  = out_cell_q.fore;
	assign cell_back  = out_cell_q.back;
	assign clipped    = out_clip_q;

	`ASSERT_SAME(a_clip_zero, out_valid_q && out_clip_q, out_cell_q == ckb_pkg::CELL_ZERO)
	`ASSERT_SAME(a_stall_blocks, valid_s1 && out_valid_q && !out_ready, !in_ready)
	`ASSERT_SAME(a_write_on_adv, wr_en, s1_adv && !clip_s1)
	`ASSERT_NEXT(a_adv_shows, s1_adv, out_valid_q)

endmodule

`default_nettype wire
